// ===== rtl/cdc_pkg.sv =====
// Package for the calendar date counter: shared types, constants and
// calendar helper functions. No dependencies.
package cdc_pkg;

  // Fixed field widths of the date words.
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned KIND_W  = 2;
  // Width of a year remainder modulo the Gregorian cycle (0 to 399).
  localparam int unsigned REM_W   = 9;
  // Width of a year length and of the day accumulator (up to 31 + 366).
  localparam int unsigned YLEN_W  = 9;
  localparam int unsigned DACC_W  = 9;

  // Calendar constants.
  localparam int unsigned DAYS_COMMON     = 365;
  localparam int unsigned DAYS_LEAP       = 366;
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned GREG_CYCLE      = 400;
  localparam int unsigned CENTURY         = 100;
  localparam int unsigned LAST_DAY        = 31;
  localparam int unsigned LAST_MONTH      = 12;

  // Reset date, and its remainder in the Gregorian cycle.
  localparam int unsigned DAY_RESET   = 1;
  localparam int unsigned MONTH_RESET = 1;
  localparam int unsigned YEAR_RESET  = 2000;
  localparam int unsigned REM_RESET   = YEAR_RESET % GREG_CYCLE;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT_DAY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_DAYS   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ADD_MONTHS = 2'd3;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_NEXT_DAY,
    OP_YEAR_STEP,
    OP_DAY_INIT,
    OP_MONTH_STEP,
    OP_DAY_WRITE,
    OP_MSUM,
    OP_MDIV_MUL,
    OP_MDIV_FIX,
    OP_MDIV_YEAR,
    OP_REM_MUL,
    OP_REM_FIX,
    OP_OUT_LOAD
  } cdc_op_e;

  // Controller to datapath.
  typedef struct packed {
    logic    capture;
    cdc_op_e op;
  } cdc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic c_gt_ylen;
    logic d_gt_mlen;
    logic msum_zero;
  } cdc_status_t;

  // Leap year from the year's remainder in the 400-year cycle.
  function automatic logic is_leap(input logic [REM_W-1:0] rem);
    return (rem[1:0] == 2'b00) &&
           (rem != REM_W'(CENTURY)) &&
           (rem != REM_W'(2 * CENTURY)) &&
           (rem != REM_W'(3 * CENTURY));
  endfunction

  // Month length; months outside one to twelve count as 30 days.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cdc_in_if.sv =====
// Input channel of the calendar date counter: handshake and item word.
// Depends on cdc_pkg.
interface cdc_in_if
  import cdc_pkg::*;
#(
  parameter int unsigned YEAR_BITS  = 14,
  parameter int unsigned COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [COUNT_BITS-1:0] count;
  logic [DAY_W-1:0]      given_day;
  logic [MONTH_W-1:0]    given_month;
  logic [YEAR_BITS-1:0]  given_year;

  modport source (
    output valid, kind, count, given_day, given_month, given_year,
    input  ready
  );
  modport sink (
    input  valid, kind, count, given_day, given_month, given_year,
    output ready
  );
endinterface

// ===== rtl/cdc_out_if.sv =====
// Result channel of the calendar date counter: handshake and result word.
// Depends on cdc_pkg.
interface cdc_out_if
  import cdc_pkg::*;
#(
  parameter int unsigned YEAR_BITS = 14
);
  logic                 valid;
  logic                 ready;
  logic [DAY_W-1:0]     cur_day;
  logic [MONTH_W-1:0]   cur_month;
  logic [YEAR_BITS-1:0] cur_year;
  logic                 year_end;
  logic                 is_before;
  logic                 is_equal;

  modport source (
    output valid, cur_day, cur_month, cur_year, year_end, is_before, is_equal,
    input  ready
  );
  modport sink (
    input  valid, cur_day, cur_month, cur_year, year_end, is_before, is_equal,
    output ready
  );
endinterface

// ===== rtl/cdc_dpath.sv =====
// Datapath of the calendar date counter: date registers, year and month
// carry logic, reciprocal dividers and the result register. Depends on cdc_pkg.
module cdc_dpath
  import cdc_pkg::*;
#(
  parameter int unsigned YEAR_BITS  = 14,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdc_cmd_t              cmd_i,
  output cdc_status_t           status_o,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [DAY_W-1:0]      given_day_i,
  input  logic [MONTH_W-1:0]    given_month_i,
  input  logic [YEAR_BITS-1:0]  given_year_i,
  output logic [DAY_W-1:0]      cur_day_o,
  output logic [MONTH_W-1:0]    cur_month_o,
  output logic [YEAR_BITS-1:0]  cur_year_o,
  output logic                  year_end_o,
  output logic                  is_before_o,
  output logic                  is_equal_o
);

  localparam int unsigned YW   = YEAR_BITS;
  localparam int unsigned CW   = COUNT_BITS;
  localparam int unsigned CMPW = (CW > YLEN_W) ? CW : YLEN_W;
  // Month sum and its divide-by-twelve unit: x / 12 = (x >> 2) / 3.
  localparam int unsigned XW   = CW + 1;
  localparam int unsigned Q3W  = XW - 3;
  localparam int unsigned M3W  = XW - 1;
  localparam int unsigned P3W  = (XW - 2) + M3W;
  localparam logic [M3W-1:0] RECIP3 = M3W'((64'd1 << XW) / 3);
  localparam int unsigned SUMW = (YW > Q3W) ? YW : Q3W;
  // Year remainder modulo 400 by reciprocal multiplication.
  localparam int unsigned K4   = YW + 9;
  localparam int unsigned Q4W  = YW - 8;
  localparam int unsigned M4W  = YW + 1;
  localparam int unsigned P4W  = YW + M4W;
  localparam logic [M4W-1:0] RECIP4 = M4W'((64'd1 << K4) / GREG_CYCLE);

  // Architectural date and the year's place in the 400-year cycle.
  logic [DAY_W-1:0]   day_q, day_d;
  logic [MONTH_W-1:0] month_q, month_d;
  logic [YW-1:0]      year_q, year_d;
  logic [REM_W-1:0]   rem_q, rem_d;

  // Working registers of one item.
  logic [CW-1:0]      c_q, c_d;
  logic [DACC_W-1:0]  d_q, d_d;
  logic [XW-1:0]      mx_q, mx_d;
  logic               mzero_q, mzero_d;
  logic [Q3W-1:0]     q3_q, q3_d;
  logic [Q3W-1:0]     kq_q, kq_d;
  logic [Q4W-1:0]     q4_q, q4_d;
  logic [DAY_W-1:0]   gd_q;
  logic [MONTH_W-1:0] gm_q;
  logic [YW-1:0]      gy_q;

  // Result register.
  logic [DAY_W-1:0]   out_day_q;
  logic [MONTH_W-1:0] out_month_q;
  logic [YW-1:0]      out_year_q;
  logic               out_end_q, out_before_q, out_equal_q;

  // Calendar lookups on the current date.
  logic                leap;
  logic [YLEN_W-1:0]   ylen;
  logic [DAY_W-1:0]    mlen;
  logic [CMPW-1:0]     c_ext;
  logic [CMPW-1:0]     c_less_year;

  assign leap        = is_leap(rem_q);
  assign ylen        = leap ? YLEN_W'(DAYS_LEAP) : YLEN_W'(DAYS_COMMON);
  assign mlen        = month_len(month_q, leap);
  assign c_ext       = CMPW'(c_q);
  assign c_less_year = c_ext - CMPW'(ylen);

  // Year increment, with the cycle remainder following it. A wrap of the
  // year register restarts the cycle at year zero.
  logic [YW-1:0]    year_inc;
  logic [REM_W-1:0] rem_inc;

  assign year_inc = year_q + YW'(1);
  assign rem_inc  = ((&year_q) || (rem_q == REM_W'(GREG_CYCLE - 1))) ?
                    '0 : rem_q + REM_W'(1);

  // Month increment in one extra bit, so that month fifteen still carries.
  logic [MONTH_W:0] month_inc;
  logic             month_wrap;

  assign month_inc  = {1'b0, month_q} + (MONTH_W + 1)'(1);
  assign month_wrap = month_inc > (MONTH_W + 1)'(MONTHS_PER_YEAR);

  // Next day.
  logic [DAY_W:0]   day_inc;
  logic             nd_ovf;
  logic [MONTH_W:0] nd_month;
  logic             nd_wrap;

  assign day_inc  = {1'b0, day_q} + (DAY_W + 1)'(1);
  assign nd_ovf   = day_inc > {1'b0, mlen};
  assign nd_month = nd_ovf ? month_inc : {1'b0, month_q};
  assign nd_wrap  = nd_month > (MONTH_W + 1)'(MONTHS_PER_YEAR);

  // Month sum for adding months.
  logic [XW-1:0] msum;

  assign msum = XW'(month_q) + XW'(c_q);

  // Divide by twelve: estimate the quotient of (x >> 2) / 3, then correct it
  // once and rebuild the month from the remainder and the two low bits.
  logic [XW-3:0]     xs;
  logic [P3W-1:0]    prod3;
  logic [XW-3:0]     r3w;
  logic [2:0]        rem3, rem3_fix;
  logic              ge3;
  logic [Q3W-1:0]    kq;
  logic [MONTH_W-1:0] month_fix;
  logic [SUMW-1:0]   year_sum;

  assign xs        = mx_q[XW-1:2];
  assign prod3     = P3W'(xs) * P3W'(RECIP3);
  assign r3w       = xs - {q3_q, 1'b0} - (XW - 2)'(q3_q);
  assign rem3      = r3w[2:0];
  assign ge3       = rem3 >= 3'd3;
  assign rem3_fix  = ge3 ? rem3 - 3'd3 : rem3;
  assign kq        = q3_q + Q3W'(ge3);
  assign month_fix = {rem3_fix[1:0], mx_q[1:0]} + MONTH_W'(1);
  assign year_sum  = SUMW'(year_q) + SUMW'(kq_q);

  // Year modulo 400: estimate the quotient, subtract 400 times it
  // (400 = 256 + 128 + 16) and correct once.
  logic [P4W-1:0]   prod4;
  logic [YW-1:0]    sub400;
  logic [YW-1:0]    r4w;
  logic [9:0]       r4;
  logic [REM_W-1:0] rem_fix;

  assign prod4   = P4W'(year_q) * P4W'(RECIP4);
  assign sub400  = (YW'(q4_q) << 8) + (YW'(q4_q) << 7) + (YW'(q4_q) << 4);
  assign r4w     = year_q - sub400;
  assign r4      = r4w[9:0];
  assign rem_fix = (r4 >= 10'(GREG_CYCLE)) ? REM_W'(r4 - 10'(GREG_CYCLE)) :
                                             r4[REM_W-1:0];

  // Status back to the controller.
  assign status_o.c_gt_ylen = c_ext > CMPW'(ylen);
  assign status_o.d_gt_mlen = d_q > DACC_W'(mlen);
  assign status_o.msum_zero = mzero_q;

  // Next-state selection by operation.
  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    rem_d   = rem_q;
    c_d     = c_q;
    d_d     = d_q;
    mx_d    = mx_q;
    mzero_d = mzero_q;
    q3_d    = q3_q;
    kq_d    = kq_q;
    q4_d    = q4_q;
    if (cmd_i.capture) begin
      c_d = count_i;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        day_d   = gd_q;
        month_d = gm_q;
        year_d  = gy_q;
      end
      OP_NEXT_DAY: begin
        day_d = nd_ovf ? DAY_W'(1) : day_inc[DAY_W-1:0];
        if (nd_wrap) begin
          month_d = MONTH_W'(1);
          year_d  = year_inc;
          rem_d   = rem_inc;
        end else begin
          month_d = nd_month[MONTH_W-1:0];
        end
      end
      OP_YEAR_STEP: begin
        c_d    = c_less_year[CW-1:0];
        year_d = year_inc;
        rem_d  = rem_inc;
      end
      OP_DAY_INIT: begin
        d_d = DACC_W'(day_q) + c_ext[DACC_W-1:0];
      end
      OP_MONTH_STEP: begin
        d_d = d_q - DACC_W'(mlen);
        if (month_wrap) begin
          month_d = MONTH_W'(1);
          year_d  = year_inc;
          rem_d   = rem_inc;
        end else begin
          month_d = month_inc[MONTH_W-1:0];
        end
      end
      OP_DAY_WRITE: begin
        day_d = d_q[DAY_W-1:0];
      end
      OP_MSUM: begin
        mx_d    = msum - XW'(1);
        mzero_d = msum == '0;
      end
      OP_MDIV_MUL: begin
        q3_d = prod3[P3W-1:XW];
      end
      OP_MDIV_FIX: begin
        month_d = month_fix;
        kq_d    = kq;
      end
      OP_MDIV_YEAR: begin
        year_d = year_sum[YW-1:0];
      end
      OP_REM_MUL: begin
        q4_d = prod4[P4W-1:K4];
      end
      OP_REM_FIX: begin
        rem_d = rem_fix;
      end
      default: begin
      end
    endcase
  end

  // Stored date.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q   <= DAY_W'(DAY_RESET);
      month_q <= MONTH_W'(MONTH_RESET);
      year_q  <= YW'(YEAR_RESET);
      rem_q   <= REM_W'(REM_RESET);
    end else begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      rem_q   <= rem_d;
    end
  end

  // Working registers and the captured given date.
  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    d_q     <= d_d;
    mx_q    <= mx_d;
    mzero_q <= mzero_d;
    q3_q    <= q3_d;
    kq_q    <= kq_d;
    q4_q    <= q4_d;
    if (cmd_i.capture) begin
      gd_q <= given_day_i;
      gm_q <= given_month_i;
      gy_q <= given_year_i;
    end
  end

  // Result register: date after the step and its comparisons.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT_LOAD) begin
      out_day_q    <= day_q;
      out_month_q  <= month_q;
      out_year_q   <= year_q;
      out_end_q    <= (day_q == DAY_W'(LAST_DAY)) && (month_q == MONTH_W'(LAST_MONTH));
      out_before_q <= {year_q, month_q, day_q} < {gy_q, gm_q, gd_q};
      out_equal_q  <= {year_q, month_q, day_q} == {gy_q, gm_q, gd_q};
    end
  end

  assign cur_day_o   = out_day_q;
  assign cur_month_o = out_month_q;
  assign cur_year_o  = out_year_q;
  assign year_end_o  = out_end_q;
  assign is_before_o = out_before_q;
  assign is_equal_o  = out_equal_q;

endmodule

// ===== rtl/cdc_ctrl.sv =====
// Controller of the calendar date counter: sequences the datapath through
// one item and owns both handshakes. Depends on cdc_pkg.
module cdc_ctrl
  import cdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cdc_status_t       status_i,
  output cdc_cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_NEXT,
    S_YEARS,
    S_MONTHS,
    S_MSUM,
    S_MDIV_MUL,
    S_MDIV_FIX,
    S_MDIV_YEAR,
    S_REM_MUL,
    S_REM_FIX,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   slot_free;

  assign in_ready_o  = state_q == S_IDLE;
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and datapath command.
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = in_fire;
    cmd_o.op      = OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_kind_i)
            KIND_LOAD:     state_d = S_LOAD;
            KIND_NEXT_DAY: state_d = S_NEXT;
            KIND_ADD_DAYS: state_d = S_YEARS;
            default:       state_d = S_MSUM;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_REM_MUL;
      end
      S_NEXT: begin
        cmd_o.op = OP_NEXT_DAY;
        state_d  = S_DONE;
      end
      // Remove whole years first, one per cycle.
      S_YEARS: begin
        if (status_i.c_gt_ylen) begin
          cmd_o.op = OP_YEAR_STEP;
        end else begin
          cmd_o.op = OP_DAY_INIT;
          state_d  = S_MONTHS;
        end
      end
      // Then carry the rest through the months, one per cycle.
      S_MONTHS: begin
        if (status_i.d_gt_mlen) begin
          cmd_o.op = OP_MONTH_STEP;
        end else begin
          cmd_o.op = OP_DAY_WRITE;
          state_d  = S_DONE;
        end
      end
      S_MSUM: begin
        cmd_o.op = OP_MSUM;
        state_d  = S_MDIV_MUL;
      end
      // A month sum of zero leaves the date as it is.
      S_MDIV_MUL: begin
        if (status_i.msum_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_MDIV_MUL;
          state_d  = S_MDIV_FIX;
        end
      end
      S_MDIV_FIX: begin
        cmd_o.op = OP_MDIV_FIX;
        state_d  = S_MDIV_YEAR;
      end
      S_MDIV_YEAR: begin
        cmd_o.op = OP_MDIV_YEAR;
        state_d  = S_REM_MUL;
      end
      // The year moved arbitrarily: rebuild its place in the 400-year cycle.
      S_REM_MUL: begin
        cmd_o.op = OP_REM_MUL;
        state_d  = S_REM_FIX;
      end
      S_REM_FIX: begin
        cmd_o.op = OP_REM_FIX;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.op = OP_OUT_LOAD;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid follows the result register's loads and the sink's takes.
  always_comb begin
    if (cmd_o.op == OP_OUT_LOAD) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/calendar_date_counter.sv =====
// Top level of the calendar date counter: controller, datapath and checks.
// Depends on cdc_pkg, cdc_in_if, cdc_out_if, cdc_ctrl and cdc_dpath.
//
//   Port    Role    Word
//   in_i    sink    kind, count, given_day, given_month, given_year
//   out_o   source  cur_day, cur_month, cur_year, year_end, is_before, is_equal
//
// One word is worked on at a time; a new word is taken once the previous
// result has entered the output register, even if that result still waits.
// Add days removes whole years one per cycle (count / 365 at most), then
// carries the rest through the months one per cycle (at most 13 carries).
// Reset gives 1 January 2000. A stalled result holds only the final state.
module calendar_date_counter
  import cdc_pkg::*;
#(
  parameter int unsigned YEAR_BITS  = 14,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdc_in_if.sink    in_i,
  cdc_out_if.source out_o
);

  cdc_cmd_t    cmd;
  cdc_status_t status;

  // Sequencer.
  cdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Date registers and arithmetic.
  cdc_dpath #(
    .YEAR_BITS  (YEAR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .count_i       (in_i.count),
    .given_day_i   (in_i.given_day),
    .given_month_i (in_i.given_month),
    .given_year_i  (in_i.given_year),
    .cur_day_o     (out_o.cur_day),
    .cur_month_o   (out_o.cur_month),
    .cur_year_o    (out_o.cur_year),
    .year_end_o    (out_o.year_end),
    .is_before_o   (out_o.is_before),
    .is_equal_o    (out_o.is_equal)
  );

  // A taken word keeps the input closed until its result is stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken again while a word is in progress");

  // Loading the result register always presents a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_OUT_LOAD |=> out_o.valid)
    else $error("result loaded without valid");

  // A date cannot both precede and equal the given date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.is_before && out_o.is_equal))
    else $error("before and equal flags both set");

endmodule
